>>> src/matrix3_transform_norm_sum_unit_macros.svh
// ----------------------------------------------------------------------------
// matrix3 transform norm sum unit assertion macros
// Shared concurrent assertion shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef MATRIX3_TRANSFORM_NORM_SUM_UNIT_MACROS_SVH
`define MATRIX3_TRANSFORM_NORM_SUM_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define M3TN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("m3tn check failed");

// consequent checked in the cycle after the antecedent
`define M3TN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("m3tn check failed");

`endif

>>> src/m3tn_pkg.sv
// ----------------------------------------------------------------------------
// m3tn_pkg
// Widths, reset values and shared types of the 3x3 transform norm unit
// ----------------------------------------------------------------------------
`default_nettype none

package m3tn_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int COEF_WIDTH  = 16;
  localparam int SUM_WIDTH   = 40;
  localparam int COEF_FRAC   = 12;
  localparam int NUM_DIMS    = 3;

  localparam int ROW_WIDTH     = NUM_DIMS * COEF_WIDTH;
  localparam int IDX_WIDTH     = $clog2(NUM_DIMS);
  localparam int CFG_IDX_WIDTH = 2;
  localparam int MUL_WIDTH     = (COEF_WIDTH > COORD_WIDTH) ? COEF_WIDTH : COORD_WIDTH;
  localparam int PROD_WIDTH    = 2 * MUL_WIDTH;
  // three products summed
  localparam int ACC_WIDTH     = PROD_WIDTH + 2;
  // three squares of saturated coordinates stay below 2^(2*COORD_WIDTH)
  localparam int SQ_WIDTH      = 2 * COORD_WIDTH;
  localparam int NORM_WIDTH    = COORD_WIDTH;
  localparam int REM_WIDTH     = NORM_WIDTH + 3;
  localparam int ROOT_CNT_WIDTH = $clog2(NORM_WIDTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(64'd1 << COEF_FRAC);
  localparam logic [ROW_WIDTH-1:0]  ROW0_RESET = ROW_WIDTH'(COEF_ONE);
  localparam logic [ROW_WIDTH-1:0]  ROW1_RESET = ROW_WIDTH'(COEF_ONE) << COEF_WIDTH;
  localparam logic [ROW_WIDTH-1:0]  ROW2_RESET = ROW_WIDTH'(COEF_ONE) << (2 * COEF_WIDTH);

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ROW0 = 2'd0,
    REG_ROW1 = 2'd1,
    REG_ROW2 = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pt_x;
    logic signed [COORD_WIDTH-1:0] pt_y;
    logic signed [COORD_WIDTH-1:0] pt_z;
    logic                          restart;
  } point_t;

endpackage

`default_nettype wire

>>> src/m3tn_if.sv
// ----------------------------------------------------------------------------
// m3tn channel interfaces
// Valid/ready channels for points, results and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface m3tn_pt_if;
  import m3tn_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pt_x;
  logic signed [COORD_WIDTH-1:0] pt_y;
  logic signed [COORD_WIDTH-1:0] pt_z;
  logic                          restart;
  modport source (output valid, pt_x, pt_y, pt_z, restart, input ready);
  modport sink (input valid, pt_x, pt_y, pt_z, restart, output ready);
endinterface

interface m3tn_res_if;
  import m3tn_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;
  logic                          clipped;
  logic [NORM_WIDTH-1:0]         norm;
  logic [SUM_WIDTH-1:0]          running_sum;
  modport source (output valid, out_x, out_y, out_z, clipped, norm, running_sum,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, clipped, norm, running_sum,
                output ready);
endinterface

interface m3tn_cfg_if;
  import m3tn_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_WIDTH-1:0] index;
  logic [ROW_WIDTH-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/m3tn_front.sv
// ----------------------------------------------------------------------------
// m3tn_front
// Point intake: takes requests and holds them in a short queue for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module m3tn_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  m3tn_pt_if.sink           pt_i,
  input  logic              pop_i,
  output logic              avail_o,
  output m3tn_pkg::point_t  head_o
);
  import m3tn_pkg::*;

  point_t                slot_q [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_WIDTH-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_WIDTH-1:0] count_q, count_d;
  logic                  push;
  logic                  pop;

  assign pt_i.ready = (count_q != QCNT_WIDTH'(QUEUE_DEPTH));
  assign push       = pt_i.valid && pt_i.ready;
  assign avail_o    = (count_q != '0);
  assign pop        = pop_i && avail_o;
  assign head_o     = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_WIDTH'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_WIDTH'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_WIDTH'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{pt_x: pt_i.pt_x, pt_y: pt_i.pt_y, pt_z: pt_i.pt_z,
                            restart: pt_i.restart};
    end
  end

endmodule

`default_nettype wire

>>> src/m3tn_isqrt.sv
// ----------------------------------------------------------------------------
// m3tn_isqrt
// Floor square root, restoring digit recurrence, one result bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module m3tn_isqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [m3tn_pkg::SQ_WIDTH-1:0]   rad_i,
  output logic                            done_o,
  output logic [m3tn_pkg::NORM_WIDTH-1:0] root_o
);
  import m3tn_pkg::*;

  logic                      busy_q;
  logic                      done_q;
  logic [ROOT_CNT_WIDTH-1:0] cnt_q;
  logic [SQ_WIDTH-1:0]       rad_q;
  logic [REM_WIDTH-1:0]      rem_q;
  logic [NORM_WIDTH-1:0]     root_q;
  logic [REM_WIDTH-1:0]      rem_sh;
  logic [REM_WIDTH-1:0]      trial;
  logic                      take;

  // bring down the next two radicand bits, try root*4+1
  assign rem_sh = {rem_q[REM_WIDTH-3:0], rad_q[SQ_WIDTH-1 -: 2]};
  assign trial  = REM_WIDTH'({root_q, 2'b01});
  assign take   = (rem_sh >= trial);

  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + ROOT_CNT_WIDTH'(1);
        if (cnt_q == ROOT_CNT_WIDTH'(NORM_WIDTH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= take ? rem_sh - trial : rem_sh;
      root_q <= {root_q[NORM_WIDTH-2:0], take};
    end
  end

endmodule

`default_nettype wire

>>> src/m3tn_back.sv
// ----------------------------------------------------------------------------
// m3tn_back
// Back end: shared multiplier for the 3x3 product and squares, root, sum
// ----------------------------------------------------------------------------
`default_nettype none

module m3tn_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  m3tn_cfg_if.sink         cfg_i,
  m3tn_res_if.source       res_o,
  input  logic             avail_i,
  input  m3tn_pkg::point_t head_i,
  output logic             pop_o
);
  import m3tn_pkg::*;

  localparam int TOT_WIDTH = ((SUM_WIDTH > NORM_WIDTH) ? SUM_WIDTH : NORM_WIDTH) + 1;
  localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(NUM_DIMS - 1);
  localparam logic signed [ACC_WIDTH-1:0] CMAX =
    (ACC_WIDTH'(1) <<< (COORD_WIDTH - 1)) - ACC_WIDTH'(1);
  localparam logic signed [ACC_WIDTH-1:0] CMIN = -CMAX - ACC_WIDTH'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_ROOT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                 vld;
    logic                 sq;
    logic [IDX_WIDTH-1:0] row;
    logic [IDX_WIDTH-1:0] col;
  } mac_tag_t;

  state_e                 state_q, state_d;
  logic                   iss_act_q, iss_act_d;
  logic                   iss_sq_q, iss_sq_d;
  logic [IDX_WIDTH-1:0]   iss_row_q, iss_row_d;
  logic [IDX_WIDTH-1:0]   iss_col_q, iss_col_d;
  mac_tag_t               tag_q, tag_d;
  logic [SUM_WIDTH-1:0]   total_q, total_d;
  logic                   out_vld_q, out_vld_d;
  logic [ROW_WIDTH-1:0]   rows_q [NUM_DIMS];

  logic signed [COORD_WIDTH-1:0] p_q [NUM_DIMS];
  logic signed [COORD_WIDTH-1:0] q_q [NUM_DIMS];
  logic                          restart_q;
  logic                          clip_q;
  logic signed [PROD_WIDTH-1:0]  prod_q;
  logic signed [ACC_WIDTH-1:0]   acc_q;
  logic [SQ_WIDTH-1:0]           ssq_q;
  logic [NORM_WIDTH-1:0]         norm_q;
  logic signed [COORD_WIDTH-1:0] out_x_q, out_y_q, out_z_q;
  logic                          out_clip_q;
  logic [NORM_WIDTH-1:0]         out_norm_q;
  logic [SUM_WIDTH-1:0]          out_sum_q;

  logic signed [COEF_WIDTH-1:0]  coef;
  logic signed [MUL_WIDTH-1:0]   mul_a, mul_b;
  logic signed [PROD_WIDTH-1:0]  prod_d;
  logic signed [ACC_WIDTH-1:0]   acc_sum;
  logic signed [ACC_WIDTH-1:0]   acc_flr;
  logic signed [COORD_WIDTH-1:0] sat_val;
  logic                          sat_clip;
  logic [SQ_WIDTH-1:0]           ssq_sum;
  logic                          sqrt_start;
  logic                          sqrt_done;
  logic [NORM_WIDTH-1:0]         sqrt_root;
  logic                          load_out;
  logic [SUM_WIDTH-1:0]          sum_base;
  logic [TOT_WIDTH-1:0]          tsum;

  // ---------------- register writes ----------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q[0] <= ROW0_RESET;
      rows_q[1] <= ROW1_RESET;
      rows_q[2] <= ROW2_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ROW0: rows_q[0] <= cfg_i.data;
        REG_ROW1: rows_q[1] <= cfg_i.data;
        REG_ROW2: rows_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------- shared multiplier ----------------
  assign coef = rows_q[iss_row_q][COEF_WIDTH*iss_col_q +: COEF_WIDTH];

  always_comb begin
    if (iss_sq_q) begin
      mul_a = MUL_WIDTH'(q_q[iss_row_q]);
      mul_b = MUL_WIDTH'(q_q[iss_row_q]);
    end else begin
      mul_a = MUL_WIDTH'(coef);
      mul_b = MUL_WIDTH'(p_q[iss_col_q]);
    end
    prod_d = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
  end

  // ---------------- accumulate, floor, saturate ----------------
  always_comb begin
    acc_sum = ((tag_q.col == '0) ? '0 : acc_q) + ACC_WIDTH'(prod_q);
    acc_flr = acc_sum >>> COEF_FRAC;
    if (acc_flr > CMAX) begin
      sat_val  = COORD_WIDTH'(CMAX);
      sat_clip = 1'b1;
    end else if (acc_flr < CMIN) begin
      sat_val  = COORD_WIDTH'(CMIN);
      sat_clip = 1'b1;
    end else begin
      sat_val  = acc_flr[COORD_WIDTH-1:0];
      sat_clip = 1'b0;
    end
    // squares are never negative and fit the sum width
    ssq_sum = ((tag_q.row == '0) ? '0 : ssq_q) + SQ_WIDTH'(prod_q);
  end

  m3tn_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (ssq_sum),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // saturating running sum
  always_comb begin
    sum_base = restart_q ? '0 : total_q;
    tsum     = TOT_WIDTH'(sum_base) + TOT_WIDTH'(norm_q);
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d    = state_q;
    iss_act_d  = iss_act_q;
    iss_sq_d   = iss_sq_q;
    iss_row_d  = iss_row_q;
    iss_col_d  = iss_col_q;
    tag_d      = '0;
    total_d    = total_q;
    out_vld_d  = out_vld_q;
    pop_o      = 1'b0;
    sqrt_start = 1'b0;
    load_out   = 1'b0;
    if (out_vld_q && res_o.ready) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (avail_i) begin
          pop_o     = 1'b1;
          iss_act_d = 1'b1;
          iss_sq_d  = 1'b0;
          iss_row_d = '0;
          iss_col_d = '0;
          state_d   = S_CALC;
        end
      end
      S_CALC: begin
        if (iss_act_q) begin
          tag_d.vld = 1'b1;
          tag_d.sq  = iss_sq_q;
          tag_d.row = iss_row_q;
          tag_d.col = iss_col_q;
          if (iss_sq_q) begin
            if (iss_row_q == LAST_IDX) begin
              iss_act_d = 1'b0;
            end else begin
              iss_row_d = iss_row_q + IDX_WIDTH'(1);
            end
          end else if (iss_col_q == LAST_IDX) begin
            iss_col_d = '0;
            // matrix done, squares follow
            if (iss_row_q == LAST_IDX) begin
              iss_sq_d  = 1'b1;
              iss_row_d = '0;
            end else begin
              iss_row_d = iss_row_q + IDX_WIDTH'(1);
            end
          end else begin
            iss_col_d = iss_col_q + IDX_WIDTH'(1);
          end
        end
        if (tag_q.vld && tag_q.sq && (tag_q.row == LAST_IDX)) begin
          sqrt_start = 1'b1;
          state_d    = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sqrt_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || res_o.ready) begin
          load_out  = 1'b1;
          out_vld_d = 1'b1;
          total_d   = (tsum > TOT_WIDTH'({SUM_WIDTH{1'b1}})) ? {SUM_WIDTH{1'b1}}
                                                              : tsum[SUM_WIDTH-1:0];
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      iss_act_q <= 1'b0;
      iss_sq_q  <= 1'b0;
      iss_row_q <= '0;
      iss_col_q <= '0;
      tag_q     <= '0;
      total_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_act_q <= iss_act_d;
      iss_sq_q  <= iss_sq_d;
      iss_row_q <= iss_row_d;
      iss_col_q <= iss_col_d;
      tag_q     <= tag_d;
      total_q   <= total_d;
      out_vld_q <= out_vld_d;
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      p_q[0]    <= head_i.pt_x;
      p_q[1]    <= head_i.pt_y;
      p_q[2]    <= head_i.pt_z;
      restart_q <= head_i.restart;
      clip_q    <= 1'b0;
    end
    prod_q <= prod_d;
    if (tag_q.vld && !tag_q.sq) begin
      if (tag_q.col == LAST_IDX) begin
        q_q[tag_q.row] <= sat_val;
        clip_q         <= clip_q | sat_clip;
      end else begin
        acc_q <= acc_sum;
      end
    end
    if (tag_q.vld && tag_q.sq) begin
      ssq_q <= ssq_sum;
    end
    if (sqrt_done) begin
      norm_q <= sqrt_root;
    end
    if (load_out) begin
      out_x_q    <= q_q[0];
      out_y_q    <= q_q[1];
      out_z_q    <= q_q[2];
      out_clip_q <= clip_q;
      out_norm_q <= norm_q;
      out_sum_q  <= total_d;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.out_x       = out_x_q;
  assign res_o.out_y       = out_y_q;
  assign res_o.out_z       = out_z_q;
  assign res_o.clipped     = out_clip_q;
  assign res_o.norm        = out_norm_q;
  assign res_o.running_sum = out_sum_q;

endmodule

`default_nettype wire

>>> src/matrix3_transform_norm_sum_unit.sv
// ----------------------------------------------------------------------------
// matrix3_transform_norm_sum_unit
// 3x3 point transform with saturated Q8.8 output, floor norm and running sum
// ----------------------------------------------------------------------------
// In the back end each point is picked from the queue, then the nine matrix
// products and three squares go through a single shared 16x16 multiplier,
// the square root follows at one result bit per cycle, and the result is
// loaded into the output register. A two-entry input queue keeps taking
// requests while a point is at work, and the output register holds a finished
// result while the next point is computed. Register writes are taken in any
// cycle and complete at once; write only while no point is in flight.
`default_nettype none

module matrix3_transform_norm_sum_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  m3tn_pt_if.sink    pt_i,
  m3tn_res_if.source res_o,
  m3tn_cfg_if.sink   cfg_i
);
  import m3tn_pkg::*;

  point_t head;
  logic   avail;
  logic   pop;

  m3tn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pt_i    (pt_i),
    .pop_i   (pop),
    .avail_o (avail),
    .head_o  (head)
  );

  m3tn_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .res_o   (res_o),
    .avail_i (avail),
    .head_i  (head),
    .pop_o   (pop)
  );

endmodule

`default_nettype wire

>>> src/m3tn_checker.sv
// ----------------------------------------------------------------------------
// m3tn_checker
// Port-level checks of the transform norm unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix3_transform_norm_sum_unit_macros.svh"

module m3tn_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    cfg_valid_i,
  input logic                                    cfg_ready_i,
  input logic                                    res_valid_i,
  input logic                                    res_ready_i,
  input logic signed [m3tn_pkg::COORD_WIDTH-1:0] res_out_x_i,
  input logic signed [m3tn_pkg::COORD_WIDTH-1:0] res_out_y_i,
  input logic signed [m3tn_pkg::COORD_WIDTH-1:0] res_out_z_i,
  input logic [m3tn_pkg::NORM_WIDTH-1:0]         res_norm_i,
  input logic [m3tn_pkg::SUM_WIDTH-1:0]          res_sum_i
);
  import m3tn_pkg::*;

  localparam int CHK_WIDTH = 2 * COORD_WIDTH + 2;

  logic signed [CHK_WIDTH-1:0] ex, ey, ez;
  logic [CHK_WIDTH-1:0]        ssq;
  logic [CHK_WIDTH-1:0]        nw;
  logic [CHK_WIDTH-1:0]        lo_sq;
  logic [CHK_WIDTH-1:0]        hi_sq;

  assign ex    = CHK_WIDTH'(res_out_x_i);
  assign ey    = CHK_WIDTH'(res_out_y_i);
  assign ez    = CHK_WIDTH'(res_out_z_i);
  assign ssq   = unsigned'(ex * ex) + unsigned'(ey * ey) + unsigned'(ez * ez);
  assign nw    = CHK_WIDTH'(res_norm_i);
  assign lo_sq = nw * nw;
  assign hi_sq = (nw + CHK_WIDTH'(1)) * (nw + CHK_WIDTH'(1));

  // stalled result holds
  `M3TN_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_norm_i) && $stable(res_sum_i) && $stable(res_out_x_i))

  // register writes never stall
  `M3TN_ASSERT_NOW(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_i)

  // norm is the floor root of the shown coordinates
  `M3TN_ASSERT_NOW(a_norm_floor, clk_i, rst_ni, res_valid_i, (lo_sq <= ssq) && (hi_sq > ssq))

  // the running sum includes this norm
  `M3TN_ASSERT_NOW(a_sum_covers, clk_i, rst_ni, res_valid_i, res_sum_i >= SUM_WIDTH'(res_norm_i))

endmodule

bind matrix3_transform_norm_sum_unit m3tn_checker u_m3tn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_out_x_i (res_o.out_x),
  .res_out_y_i (res_o.out_y),
  .res_out_z_i (res_o.out_z),
  .res_norm_i  (res_o.norm),
  .res_sum_i   (res_o.running_sum)
);

`default_nettype wire

>>> test/matrix3_transform_norm_sum_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_transform_norm_sum_unit testbench
// Drives points through the 3x3 transform, predicts each saturated output
// point, its floor norm and the running norm sum, and checks every result
// in order under random idle cycles on both channels and register rewrites
// ----------------------------------------------------------------------------

module matrix3_transform_norm_sum_unit_tb;

  import m3tn_pkg::*;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int JAM_CYCLES    = 300;
  localparam int PHASE_POINTS  = 125;
  localparam int MAX_PRINTED   = 30;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE = 2'd3;
  localparam logic [63:0] SUM_TOP = (64'd1 << SUM_WIDTH) - 64'd1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          clipped;
    logic [NORM_WIDTH-1:0]         norm;
    logic [SUM_WIDTH-1:0]          running_sum;
  } xform_result_t;

  logic clk;
  logic rst_n;

  m3tn_pt_if  pt_ch ();
  m3tn_res_if res_ch ();
  m3tn_cfg_if cfg_ch ();

  matrix3_transform_norm_sum_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pt_i   (pt_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // predictor state
  logic [ROW_WIDTH-1:0] mat_rows [3];
  logic [63:0]          norm_acc;
  xform_result_t        pending_results [$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned points_sent;
  int unsigned results_checked;
  int unsigned clipped_seen;
  int unsigned restarts_seen;
  int unsigned matrix_loads;

  bit src_steady;
  bit sink_steady;
  bit jam_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAIL matrix3_transform_norm_sum_unit");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    if (error_count < MAX_PRINTED) begin
      $display("ERROR cycle %0d: %s", cycle_count, msg);
    end
    error_count++;
  endtask

  function automatic logic [ROW_WIDTH-1:0] pack_row(logic [COEF_WIDTH-1:0] c0, c1, c2);
    return {c2, c1, c0};
  endfunction

  function automatic logic [COORD_WIDTH-1:0] corner_value(int unsigned k);
    case (k)
      0:       return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      1:       return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return COORD_WIDTH'(1);
    endcase
  endfunction

  function automatic logic [COORD_WIDTH-1:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return COORD_WIDTH'($urandom);
    if (pick == 6) return corner_value($urandom_range(0, 4));
    return COORD_WIDTH'($urandom_range(0, 1024)) - COORD_WIDTH'(512);
  endfunction

  function automatic logic [ROW_WIDTH-1:0] rand_row();
    logic [COEF_WIDTH-1:0] c [3];
    int i;
    for (i = 0; i < 3; i++) begin
      case ($urandom_range(0, 3))
        0:       c[i] = COEF_WIDTH'($urandom);
        // roughly -2.0 .. +2.0
        1:       c[i] = COEF_WIDTH'($urandom_range(0, 16384)) - COEF_WIDTH'(8192);
        2:       c[i] = COEF_WIDTH'(corner_value($urandom_range(0, 4)));
        default: c[i] = $urandom_range(0, 1) ? COEF_ONE : -COEF_ONE;
      endcase
    end
    return pack_row(c[0], c[1], c[2]);
  endfunction

  // exact dot products, floor to Q8.8, saturate, floor root, saturating sum
  function automatic xform_result_t transform_point(point_t p);
    xform_result_t r;
    longint crd [3];
    longint q [3];
    longint acc;
    longint coef;
    longint lim_hi;
    longint lim_lo;
    logic [63:0] sq;
    logic [63:0] root;
    logic [63:0] trial;
    int i;
    int j;
    int k;
    crd[0] = p.pt_x;
    crd[1] = p.pt_y;
    crd[2] = p.pt_z;
    lim_hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    lim_lo = -lim_hi - 1;
    r.clipped = 1'b0;
    sq = '0;
    for (i = 0; i < 3; i++) begin
      acc = 0;
      for (j = 0; j < 3; j++) begin
        coef = longint'($signed(mat_rows[i][j*COEF_WIDTH +: COEF_WIDTH]));
        acc += coef * crd[j];
      end
      acc = acc >>> COEF_FRAC;
      if (acc > lim_hi) begin
        acc = lim_hi;
        r.clipped = 1'b1;
      end else if (acc < lim_lo) begin
        acc = lim_lo;
        r.clipped = 1'b1;
      end
      q[i] = acc;
      sq += 64'(acc * acc);
    end
    root = '0;
    for (k = NORM_WIDTH - 1; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if (trial * trial <= sq) root = trial;
    end
    if (p.restart) begin
      norm_acc = '0;
      restarts_seen++;
    end
    if (root > SUM_TOP - norm_acc) norm_acc = SUM_TOP;
    else norm_acc = norm_acc + root;
    r.out_x       = COORD_WIDTH'(q[0]);
    r.out_y       = COORD_WIDTH'(q[1]);
    r.out_z       = COORD_WIDTH'(q[2]);
    r.norm        = NORM_WIDTH'(root);
    r.running_sum = SUM_WIDTH'(norm_acc);
    return r;
  endfunction

  // checks results first, then tracks register writes and new requests
  always @(posedge clk) begin : scoreboard
    xform_result_t want;
    point_t        pin;
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result arrived with no request pending");
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (want.clipped) clipped_seen++;
          if (res_ch.out_x !== want.out_x)
            report_mismatch($sformatf("out_x got %h want %h", res_ch.out_x, want.out_x));
          if (res_ch.out_y !== want.out_y)
            report_mismatch($sformatf("out_y got %h want %h", res_ch.out_y, want.out_y));
          if (res_ch.out_z !== want.out_z)
            report_mismatch($sformatf("out_z got %h want %h", res_ch.out_z, want.out_z));
          if (res_ch.clipped !== want.clipped)
            report_mismatch($sformatf("clipped got %b want %b", res_ch.clipped,
                                      want.clipped));
          if (res_ch.norm !== want.norm)
            report_mismatch($sformatf("norm got %h want %h", res_ch.norm, want.norm));
          if (res_ch.running_sum !== want.running_sum)
            report_mismatch($sformatf("running_sum got %h want %h", res_ch.running_sum,
                                      want.running_sum));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_ROW0: mat_rows[0] = cfg_ch.data;
          REG_ROW1: mat_rows[1] = cfg_ch.data;
          REG_ROW2: mat_rows[2] = cfg_ch.data;
          default: ;
        endcase
      end
      if (pt_ch.valid && pt_ch.ready) begin
        pin.pt_x    = pt_ch.pt_x;
        pin.pt_y    = pt_ch.pt_y;
        pin.pt_z    = pt_ch.pt_z;
        pin.restart = pt_ch.restart;
        pending_results.insert(pending_results.size(), transform_point(pin));
      end
    end
  end

  // result side ready pattern, with a long hold-off on request
  initial begin : sink_drive
    int unsigned hold;
    int unsigned pick;
    hold = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (jam_req) begin
        jam_req = 1'b0;
        hold = JAM_CYCLES;
      end
      if (hold != 0) begin
        res_ch.ready <= 1'b0;
        hold--;
      end else if (sink_steady) begin
        res_ch.ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          res_ch.ready <= 1'b1;
        end else begin
          res_ch.ready <= 1'b0;
          hold = (pick < 96) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        end
      end
    end
  end

  // valid stays high when the next request follows with no gap
  task automatic send_point(logic signed [COORD_WIDTH-1:0] x, y, z, input logic rs);
    int unsigned gap;
    int unsigned pick;
    gap = 0;
    if (!src_steady) begin
      pick = $urandom_range(0, 99);
      if (pick >= 92) gap = $urandom_range(6, 40);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      pt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_ch.valid   <= 1'b1;
    pt_ch.pt_x    <= x;
    pt_ch.pt_y    <= y;
    pt_ch.pt_z    <= z;
    pt_ch.restart <= rs;
    @(posedge clk);
    while (!pt_ch.ready) @(posedge clk);
    points_sent++;
  endtask

  task automatic settle();
    pt_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // writes all three rows back to back, optionally a write to the unused index
  task automatic load_matrix(logic [ROW_WIDTH-1:0] r0, r1, r2, input bit poke_spare);
    logic [ROW_WIDTH-1:0]     vals [4];
    logic [CFG_IDX_WIDTH-1:0] idxs [4];
    int n;
    int k;
    vals = '{r0, r1, r2, ~r0};
    idxs = '{REG_ROW0, REG_ROW1, REG_ROW2, REG_SPARE};
    n = poke_spare ? 4 : 3;
    for (k = 0; k < n; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idxs[k];
      cfg_ch.data  <= vals[k];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    matrix_loads++;
  endtask

  task automatic test_identity();
    send_point(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_point(16'h8000, 16'h7FFF, 16'h0001, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    settle();
  endtask

  // largest and smallest coefficients push the first two rows past the coordinate range
  task automatic test_saturation();
    load_matrix(pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                pack_row(16'h8000, 16'h8000, 16'h8000),
                pack_row(16'h0001, 16'hFFFF, 16'h0000), 1'b1);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_point(16'h0001, 16'h0001, 16'h0001, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_point(16'h0100, 16'h0000, 16'h0000, 1'b0);
    send_point(16'h0000, 16'h0100, 16'h0000, 1'b0);
    send_point(16'h0000, 16'h0000, 16'h0100, 1'b0);
    settle();
  endtask

  task automatic test_restart_sum();
    load_matrix(ROW0_RESET, ROW1_RESET, ROW2_RESET, 1'b0);
    send_point(16'h0300, 16'h0400, 16'h0000, 1'b1);
    send_point(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
    send_point(16'h0001, 16'h0000, 16'h0000, 1'b0);
    send_point(16'h0000, 16'h0C00, 16'h0500, 1'b1);
    send_point(16'h8000, 16'h0000, 16'h0000, 1'b0);
    send_point(16'h1234, 16'hEDCB, 16'h0F0F, 1'b0);
    settle();
  endtask

  // results held back long enough that the input side must stall
  task automatic test_backpressure();
    int i;
    load_matrix(rand_row(), rand_row(), rand_row(), 1'b0);
    src_steady = 1'b1;
    jam_req = 1'b1;
    for (i = 0; i < 30; i++) begin
      send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 15) == 0);
    end
    src_steady = 1'b0;
    settle();
  endtask

  task automatic test_random();
    int ph;
    int i;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_matrix('0, '0, '0, 1'b0);
        1: load_matrix({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 1'b0);
        2: load_matrix({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 1'b0);
        3: load_matrix('1, '1, '1, 1'b1);
        4: load_matrix(ROW0_RESET, ROW1_RESET, ROW2_RESET, 1'b0);
        default: load_matrix(rand_row(), rand_row(), rand_row(), 1'b0);
      endcase
      src_steady  = (ph % 3 == 1);
      sink_steady = (ph % 3 == 2);
      for (i = 0; i < PHASE_POINTS; i++) begin
        send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 15) == 0);
      end
      src_steady  = 1'b0;
      sink_steady = 1'b0;
      settle();
    end
  endtask

  initial begin : main_seq
    cycle_count     = 0;
    error_count     = 0;
    points_sent     = 0;
    results_checked = 0;
    clipped_seen    = 0;
    restarts_seen   = 0;
    matrix_loads    = 0;
    src_steady      = 1'b0;
    sink_steady     = 1'b0;
    jam_req         = 1'b0;
    mat_rows[0]     = ROW0_RESET;
    mat_rows[1]     = ROW1_RESET;
    mat_rows[2]     = ROW2_RESET;
    norm_acc        = '0;

    rst_n         <= 1'b0;
    pt_ch.valid   <= 1'b0;
    pt_ch.pt_x    <= '0;
    pt_ch.pt_y    <= '0;
    pt_ch.pt_z    <= '0;
    pt_ch.restart <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_ROW0;
    cfg_ch.data   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_identity();
    test_saturation();
    test_restart_sum();
    test_backpressure();
    test_random();

    $display("run covered %0d points over %0d matrix loads and %0d sum restarts",
             points_sent, matrix_loads, restarts_seen);
    $display("%0d results checked, %0d of them saturated, %0d mismatches",
             results_checked, clipped_seen, error_count);
    if (error_count == 0) begin
      $display("PASS matrix3_transform_norm_sum_unit");
    end else begin
      $display("FAIL matrix3_transform_norm_sum_unit");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/m3tn_pkg.sv
src/m3tn_if.sv
src/m3tn_front.sv
src/m3tn_isqrt.sv
src/m3tn_back.sv
src/matrix3_transform_norm_sum_unit.sv
src/m3tn_checker.sv
test/matrix3_transform_norm_sum_unit_tb.sv
